[rtl/frsg_pkg.sv]
`timescale 1ns / 1ps
// frsg_pkg: shared widths, types, state encodings and the Gaussian table
// for the fuzzy rule strength generator. No dependencies.
package frsg_pkg;

    localparam int VALUE_WIDTH     = 16;
    localparam int EXP_TABLE_DEPTH = 256;

    localparam int MAG_W   = 15;                      // centre, factor, limit
    localparam int ANG_W   = 16;                      // angle bounds
    localparam int CFG_W   = 16;                      // config data port
    localparam int CIDX_W  = 4;                       // config index port
    localparam int MU_W    = 16;                      // membership, Q0.16
    localparam int RULE_W  = 4;
    localparam int NUM_REGS = 8;
    localparam int W_W     = 2 * MAG_W - 12;          // set width
    localparam int D_W     = (VALUE_WIDTH > MAG_W + 1 ? VALUE_WIDTH : MAG_W + 1) + 1;
    localparam int RW      = W_W + 1;                 // divider remainder
    localparam int Q_W     = 16;                      // quotient bits
    localparam int FR_W    = 15;                      // interpolation fraction
    localparam int IDX_W   = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int P_W     = Q_W + $clog2(EXP_TABLE_DEPTH + 1);
    localparam int DIV_CYC = Q_W / 2;                 // two quotient bits a cycle
    localparam int CNT_W   = $clog2(DIV_CYC);
    localparam logic [MU_W-1:0] MU_ONE = '1;

    localparam longint unsigned E_INV_Q32 = 64'd1580030169;
    localparam longint unsigned DEPTH_SQ  =
        longint'(EXP_TABLE_DEPTH) * longint'(EXP_TABLE_DEPTH);

    typedef enum logic [CIDX_W-1:0] {
        REG_POS_CENTRE  = 4'd0,
        REG_VEL_CENTRE  = 4'd1,
        REG_ANG_CENTRE  = 4'd2,
        REG_RATE_CENTRE = 4'd3,
        REG_WIDTH_FAC   = 4'd4,
        REG_POS_LIMIT   = 4'd5,
        REG_ANGLE_LOW   = 4'd6,
        REG_ANGLE_HIGH  = 4'd7
    } t_reg_idx;

    typedef struct packed {
        logic [3:0][MAG_W-1:0]   centre;
        logic [MAG_W-1:0]        width_factor;
        logic [MAG_W-1:0]        position_limit;
        logic signed [ANG_W-1:0] angle_low;
        logic signed [ANG_W-1:0] angle_high;
    } t_cfg;

    typedef struct packed {
        logic [3:0][1:0][MU_W-1:0] mu;   // [value][set]
        logic                      failed;
    } t_rec;

    typedef enum logic [2:0] {
        L_IDLE, L_DIV, L_LOOK, L_MUL, L_SUB
    } t_lane_st;

    typedef enum logic [1:0] {
        F_IDLE, F_WID, F_START, F_RUN
    } t_front_st;

    typedef logic [EXP_TABLE_DEPTH:0][MU_W-1:0] t_rom;

    // exp(-z), z in Q16.16, result Q0.16 saturated
    function automatic logic [MU_W-1:0] exp_neg(input longint unsigned z);
        longint unsigned n;
        longint unsigned f;
        longint unsigned term;
        longint          sum;
        longint unsigned r;
        n    = z >> 16;
        f    = z & 64'hFFFF;
        term = 64'd1 << 32;
        sum  = longint'(term);
        term = ((term * f) >> 16) / 1;  sum = sum - longint'(term);
        term = ((term * f) >> 16) / 2;  sum = sum + longint'(term);
        term = ((term * f) >> 16) / 3;  sum = sum - longint'(term);
        term = ((term * f) >> 16) / 4;  sum = sum + longint'(term);
        term = ((term * f) >> 16) / 5;  sum = sum - longint'(term);
        term = ((term * f) >> 16) / 6;  sum = sum + longint'(term);
        term = ((term * f) >> 16) / 7;  sum = sum - longint'(term);
        term = ((term * f) >> 16) / 8;  sum = sum + longint'(term);
        term = ((term * f) >> 16) / 9;  sum = sum - longint'(term);
        term = ((term * f) >> 16) / 10; sum = sum + longint'(term);
        term = ((term * f) >> 16) / 11; sum = sum - longint'(term);
        term = ((term * f) >> 16) / 12; sum = sum + longint'(term);
        r = longint'(sum);
        for (int j = 0; j < 64; j++) begin
            if (longint'(j) < n && r != 0) r = (r * E_INV_Q32) >> 32;
        end
        r = (r + 64'd32768) >> 16;
        return (r > 64'd65535) ? MU_ONE : MU_W'(r);
    endfunction

    function automatic t_rom gauss_rom_init();
        t_rom rom;
        for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
            rom[i] = exp_neg(((64'd32 * longint'(i) * longint'(i)) << 16) / DEPTH_SQ);
        end
        return rom;
    endfunction

    localparam t_rom GAUSS_ROM = gauss_rom_init();

endpackage

[rtl/frsg_lane.sv]
`timescale 1ns / 1ps
// frsg_lane: one membership function unit (shoulder check, serial divide,
// table interpolation). Depends on frsg_pkg.
module frsg_lane (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [frsg_pkg::VALUE_WIDTH-1:0] i_x,
    input  logic [frsg_pkg::MAG_W-1:0]            i_mag,
    input  logic                                  i_pos,
    input  logic [frsg_pkg::W_W-1:0]              i_w,
    output logic                                  o_idle,
    output logic [frsg_pkg::MU_W-1:0]             o_mu
);
    frsg_pkg::t_lane_st r_st, n_st;
    logic [frsg_pkg::CNT_W-1:0] r_cnt;
    logic [frsg_pkg::RW-1:0]    r_rem, n_rem;
    logic [frsg_pkg::Q_W-1:0]   r_num, n_num, r_q, n_q;
    logic [frsg_pkg::W_W-1:0]   r_w;
    logic                       r_one, r_zero;
    logic [frsg_pkg::MU_W-1:0]  r_t0, r_diff, r_mu;
    logic [frsg_pkg::FR_W-1:0]  r_fr;
    logic [frsg_pkg::MU_W+frsg_pkg::FR_W-1:0] r_prod;

    logic signed [frsg_pkg::D_W:0] xs, ms, ds;
    logic [frsg_pkg::D_W-1:0]      d;
    logic                          one_c, zero_c;
    logic [frsg_pkg::RW-1:0]       t;
    logic [frsg_pkg::P_W-1:0]      p;
    logic [frsg_pkg::IDX_W-1:0]    idx;
    logic [frsg_pkg::MU_W-1:0]     t0, t1;

    // distance to the centre and shoulder test
    always_comb begin
        xs = (frsg_pkg::D_W+1)'(i_x);
        ms = $signed({{(frsg_pkg::D_W+1-frsg_pkg::MAG_W){1'b0}}, i_mag});
        ds = i_pos ? (ms - xs) : (xs + ms);
        one_c  = (ds <= 0);
        d      = ds[frsg_pkg::D_W-1:0];
        zero_c = ((frsg_pkg::D_W+4)'(d) >= (frsg_pkg::D_W+4)'({i_w, 3'b000}));
    end

    // two restoring steps a cycle
    always_comb begin
        n_rem = r_rem;
        n_num = r_num;
        n_q   = r_q;
        t     = '0;
        for (int s = 0; s < 2; s++) begin
            t     = {n_rem[frsg_pkg::RW-2:0], n_num[frsg_pkg::Q_W-1]};
            n_num = {n_num[frsg_pkg::Q_W-2:0], 1'b0};
            if (t >= {1'b0, r_w}) begin
                n_rem = t - {1'b0, r_w};
                n_q   = {n_q[frsg_pkg::Q_W-2:0], 1'b1};
            end else begin
                n_rem = t;
                n_q   = {n_q[frsg_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        p   = frsg_pkg::P_W'(r_q) * frsg_pkg::P_W'(frsg_pkg::EXP_TABLE_DEPTH);
        idx = frsg_pkg::IDX_W'(p >> frsg_pkg::FR_W);
        t0  = frsg_pkg::GAUSS_ROM[idx];
        t1  = frsg_pkg::GAUSS_ROM[idx + 1'b1];
        if (t1 > t0) t1 = t0;
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            frsg_pkg::L_IDLE: if (i_start) n_st = frsg_pkg::L_DIV;
            frsg_pkg::L_DIV:  if (r_cnt == frsg_pkg::CNT_W'(frsg_pkg::DIV_CYC - 1))
                                  n_st = frsg_pkg::L_LOOK;
            frsg_pkg::L_LOOK: n_st = frsg_pkg::L_MUL;
            frsg_pkg::L_MUL:  n_st = frsg_pkg::L_SUB;
            frsg_pkg::L_SUB:  n_st = frsg_pkg::L_IDLE;
            default:          n_st = frsg_pkg::L_IDLE;
        endcase
    end

    always_comb begin
        o_idle = (r_st == frsg_pkg::L_IDLE);
    end

    assign o_mu = r_mu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= frsg_pkg::L_IDLE;
            r_cnt <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == frsg_pkg::L_DIV) r_cnt <= r_cnt + 1'b1;
            else                         r_cnt <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            frsg_pkg::L_IDLE: if (i_start) begin
                r_w    <= i_w;
                r_one  <= one_c;
                r_zero <= zero_c;
                r_rem  <= frsg_pkg::RW'(d >> 4);
                r_num  <= {d[3:0], 12'h000};
                r_q    <= '0;
            end
            frsg_pkg::L_DIV: begin
                r_rem <= n_rem;
                r_num <= n_num;
                r_q   <= n_q;
            end
            frsg_pkg::L_LOOK: begin
                r_t0   <= t0;
                r_diff <= t0 - t1;
                r_fr   <= p[frsg_pkg::FR_W-1:0];
            end
            frsg_pkg::L_MUL: begin
                r_prod <= r_diff * r_fr;
            end
            frsg_pkg::L_SUB: begin
                if (r_one)       r_mu <= frsg_pkg::MU_ONE;
                else if (r_zero) r_mu <= '0;
                else r_mu <= r_t0 - frsg_pkg::MU_W'(r_prod >> frsg_pkg::FR_W);
            end
            default: ;
        endcase
    end
endmodule

[rtl/frsg_front.sv]
`timescale 1ns / 1ps
// frsg_front: accepts items, computes set widths and the fail flag, runs
// the eight membership lanes and pushes a record. Depends on frsg_pkg, frsg_lane.
module frsg_front (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  frsg_pkg::t_cfg                         i_cfg,
    input  logic                                   i_push,
    output logic                                   o_full,
    input  logic [3:0][frsg_pkg::VALUE_WIDTH-1:0]  i_x,
    input  logic                                   i_q_full,
    output logic                                   o_q_push,
    output frsg_pkg::t_rec                         o_rec
);
    localparam int XW = frsg_pkg::VALUE_WIDTH + frsg_pkg::ANG_W + 1;

    frsg_pkg::t_front_st r_st, n_st;
    logic [3:0][frsg_pkg::VALUE_WIDTH-1:0] r_x;
    logic [3:0][frsg_pkg::W_W-1:0]         r_w;
    logic                                  r_failed;
    logic [3:0][1:0]                       lane_idle;
    logic [3:0][1:0][frsg_pkg::MU_W-1:0]   lane_mu;
    logic                                  start, all_idle, accept, fail_c;
    logic signed [XW-1:0]                  pos_s, ang_s, lim_s;

    assign accept   = i_push && !o_full;
    assign all_idle = &lane_idle;

    always_comb begin
        pos_s  = XW'($signed(r_x[0]));
        ang_s  = XW'($signed(r_x[2]));
        lim_s  = $signed({{(XW-frsg_pkg::MAG_W){1'b0}}, i_cfg.position_limit});
        fail_c = (pos_s < -lim_s) || (pos_s > lim_s) ||
                 (ang_s < XW'($signed(i_cfg.angle_low))) ||
                 (ang_s > XW'($signed(i_cfg.angle_high)));
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            frsg_pkg::F_IDLE:  if (accept) n_st = frsg_pkg::F_WID;
            frsg_pkg::F_WID:   n_st = frsg_pkg::F_START;
            frsg_pkg::F_START: n_st = frsg_pkg::F_RUN;
            frsg_pkg::F_RUN:   if (all_idle && !i_q_full) n_st = frsg_pkg::F_IDLE;
            default:           n_st = frsg_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_full   = (r_st != frsg_pkg::F_IDLE);
        start    = (r_st == frsg_pkg::F_START);
        o_q_push = (r_st == frsg_pkg::F_RUN) && all_idle && !i_q_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= frsg_pkg::F_IDLE;
        else          r_st <= n_st;
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_x <= i_x;
        if (r_st == frsg_pkg::F_WID) begin
            r_failed <= fail_c;
            for (int v = 0; v < 4; v++) begin
                r_w[v] <= frsg_pkg::W_W'(((2*frsg_pkg::MAG_W)'(i_cfg.centre[v]) *
                                          (2*frsg_pkg::MAG_W)'(i_cfg.width_factor)) >> 12);
            end
        end
    end

    for (genvar v = 0; v < 4; v++) begin : g_val
        for (genvar s = 0; s < 2; s++) begin : g_set
            frsg_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_start (start),
                .i_x     (r_x[v]),
                .i_mag   (i_cfg.centre[v]),
                .i_pos   (s != 0),
                .i_w     (r_w[v]),
                .o_idle  (lane_idle[v][s]),
                .o_mu    (lane_mu[v][s])
            );
        end
    end

    assign o_rec.mu     = lane_mu;
    assign o_rec.failed = r_failed;
endmodule

[rtl/frsg_queue.sv]
`timescale 1ns / 1ps
// frsg_queue: two-entry queue of membership records between front and back.
// Depends on frsg_pkg.
module frsg_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  frsg_pkg::t_rec i_rec,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output frsg_pkg::t_rec o_rec
);
    frsg_pkg::t_rec r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_rec   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_rec;
    end
endmodule

[rtl/frsg_back.sv]
`timescale 1ns / 1ps
// frsg_back: walks the sixteen rules of a record, one min-of-four a cycle
// while the output register is free or popped, into that register. Depends on frsg_pkg.
module frsg_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  frsg_pkg::t_rec                    i_rec,
    input  logic                              i_q_empty,
    output logic                              o_q_pop,
    output logic                              o_empty,
    input  logic                              i_pop,
    output logic [frsg_pkg::RULE_W-1:0]       o_rule_index,
    output logic [frsg_pkg::MU_W-1:0]         o_strength,
    output logic                              o_last_rule,
    output logic                              o_failed
);
    frsg_pkg::t_rec              r_rec;
    logic [frsg_pkg::RULE_W-1:0] r_k;
    logic                        r_busy, r_ovalid;
    logic                        adv, last;
    logic [frsg_pkg::MU_W-1:0]   m;

    assign adv     = r_busy && (!r_ovalid || i_pop);
    assign last    = (r_k == '1);
    assign o_q_pop = (!r_busy || (adv && last)) && !i_q_empty;
    assign o_empty = !r_ovalid;

    always_comb begin
        m = r_rec.mu[0][r_k[3]];
        if (r_rec.mu[1][r_k[2]] < m) m = r_rec.mu[1][r_k[2]];
        if (r_rec.mu[2][r_k[1]] < m) m = r_rec.mu[2][r_k[1]];
        if (r_rec.mu[3][r_k[0]] < m) m = r_rec.mu[3][r_k[0]];
        if (m == '0) m = frsg_pkg::MU_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
            r_k      <= '0;
        end else begin
            if (adv)        r_ovalid <= 1'b1;
            else if (i_pop) r_ovalid <= 1'b0;
            if (o_q_pop) begin
                r_busy <= 1'b1;
                r_k    <= '0;
            end else if (adv) begin
                r_k <= r_k + 1'b1;
                if (last) r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_rec <= i_rec;
        if (adv) begin
            o_rule_index <= r_k;
            o_strength   <= m;
            o_last_rule  <= last;
            o_failed     <= r_rec.failed;
        end
    end
endmodule

[rtl/fuzzy_rule_strength_generator_top.sv]
`timescale 1ns / 1ps
// fuzzy_rule_strength_generator_top: config registers, front, queue, back.
// Depends on frsg_pkg, frsg_front, frsg_queue, frsg_back.
// Path: an item passes the front (widths, lanes), the two-entry queue and the back end.
// The back end emits one rule a cycle while the receiver keeps popping;
//   the front end (radix-4 divide per lane plus table lookup) holds one item at a time.
// Reset: synchronous active-low i_rst_n clears control and loads register defaults.
module fuzzy_rule_strength_generator_top (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [frsg_pkg::CIDX_W-1:0]            i_cfg_index,
    input  logic [frsg_pkg::CFG_W-1:0]             i_cfg_data,
    // item input
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [frsg_pkg::VALUE_WIDTH-1:0] i_position,
    input  logic signed [frsg_pkg::VALUE_WIDTH-1:0] i_velocity,
    input  logic signed [frsg_pkg::VALUE_WIDTH-1:0] i_angle,
    input  logic signed [frsg_pkg::VALUE_WIDTH-1:0] i_angular_rate,
    // results
    output logic                                   empty,
    input  logic                                   pop,
    output logic [frsg_pkg::RULE_W-1:0]            o_rule_index,
    output logic [frsg_pkg::MU_W-1:0]              o_strength,
    output logic                                   o_last_rule,
    output logic                                   o_failed
);
    frsg_pkg::t_cfg r_cfg;
    frsg_pkg::t_rec f_rec, q_rec;
    logic           q_push, q_full, q_pop, q_empty;
    logic [3:0][frsg_pkg::VALUE_WIDTH-1:0] x_in;

    assign x_in = {i_angular_rate, i_angle, i_velocity, i_position};

    // Register file; indexes past the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.centre[0]      <= 15'd6144;
            r_cfg.centre[1]      <= 15'd2048;
            r_cfg.centre[2]      <= 15'd7373;
            r_cfg.centre[3]      <= 15'd205;
            r_cfg.width_factor   <= 15'd4096;
            r_cfg.position_limit <= 15'd9830;
            r_cfg.angle_low      <= -16'sd858;
            r_cfg.angle_high     <= 16'sd858;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                frsg_pkg::REG_POS_CENTRE:  r_cfg.centre[0] <= i_cfg_data[14:0];
                frsg_pkg::REG_VEL_CENTRE:  r_cfg.centre[1] <= i_cfg_data[14:0];
                frsg_pkg::REG_ANG_CENTRE:  r_cfg.centre[2] <= i_cfg_data[14:0];
                frsg_pkg::REG_RATE_CENTRE: r_cfg.centre[3] <= i_cfg_data[14:0];
                frsg_pkg::REG_WIDTH_FAC:   r_cfg.width_factor <= i_cfg_data[14:0];
                frsg_pkg::REG_POS_LIMIT:   r_cfg.position_limit <= i_cfg_data[14:0];
                frsg_pkg::REG_ANGLE_LOW:   r_cfg.angle_low <= $signed(i_cfg_data);
                frsg_pkg::REG_ANGLE_HIGH:  r_cfg.angle_high <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // Front: one item in flight through the eight membership lanes.
    frsg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .o_full   (full),
        .i_x      (x_in),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_rec    (f_rec)
    );

    // Two records of slack so the front keeps working while results stall.
    frsg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (f_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_rec   (q_rec)
    );

    // Back: sixteen rules per record, position set outermost.
    frsg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec        (q_rec),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_rule_index (o_rule_index),
        .o_strength   (o_strength),
        .o_last_rule  (o_last_rule),
        .o_failed     (o_failed)
    );
endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// testbench: self-checking bench for fuzzy_rule_strength_generator_top.
// Depends on frsg_pkg and the block's RTL; a local rule strength predictor checks every result.
module testbench;
    import frsg_pkg::*;

    // clock and reset
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #1 i_clk = ~i_clk;

    // block ports
    logic                          i_cfg_we = 1'b0;
    logic [CIDX_W-1:0]             i_cfg_index = '0;
    logic [CFG_W-1:0]              i_cfg_data = '0;
    logic                          push = 1'b0;
    logic                          full;
    logic signed [VALUE_WIDTH-1:0] i_position = '0;
    logic signed [VALUE_WIDTH-1:0] i_velocity = '0;
    logic signed [VALUE_WIDTH-1:0] i_angle = '0;
    logic signed [VALUE_WIDTH-1:0] i_angular_rate = '0;
    logic                          empty;
    logic                          pop = 1'b0;
    logic [RULE_W-1:0]             o_rule_index;
    logic [MU_W-1:0]               o_strength;
    logic                          o_last_rule;
    logic                          o_failed;

    fuzzy_rule_strength_generator_top u_dut (.*);

    // one expected rule result
    typedef struct {
        logic [RULE_W-1:0] rule;
        logic [MU_W-1:0]   strength;
        logic              last;
        logic              failed;
    } t_rule_res;

    t_rule_res rule_q[$];
    int        err_cnt = 0;
    int        push_idle_pct = 0;   // sender idle percentage
    int        pop_idle_pct = 0;    // receiver idle percentage
    int        stall_cnt = 0;
    logic [MU_W-1:0] exp_tab [0:EXP_TABLE_DEPTH];

    // shadow registers: centres, factor, limit, angle window
    logic [MAG_W-1:0]        sh_centre [4];
    logic [MAG_W-1:0]        sh_factor;
    logic [MAG_W-1:0]        sh_limit;
    logic signed [ANG_W-1:0] sh_alo, sh_ahi;

    // exp(-z), z in Q16.16, Taylor sum then powers of 1/e
    function automatic logic [MU_W-1:0] gauss_sample(input longint unsigned z);
        longint unsigned whole, frac, term, r;
        longint          acc;
        whole = z >> 16;
        frac  = z & 64'hFFFF;
        term  = 64'd1 << 32;
        acc   = longint'(term);
        for (int k = 1; k <= 12; k++) begin
            term = ((term * frac) >> 16) / k;
            if (k % 2) acc = acc - longint'(term);
            else       acc = acc + longint'(term);
        end
        r = longint'(acc);
        while (whole > 0 && r != 0) begin
            r = (r * 64'd1580030169) >> 32;
            whole--;
        end
        r = (r + 64'd32768) >> 16;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic logic [MU_W-1:0] set_membership(input longint x, input longint mag,
                                                      input bit pos_set);
        longint unsigned w, d, u, p, idx, fr, t0, t1;
        w = (mag * longint'(sh_factor)) >> 12;
        if (pos_set) begin
            if (x >= mag) return 16'hFFFF;
            d = mag - x;
        end else begin
            if (x <= -mag) return 16'hFFFF;
            d = x + mag;
        end
        if (w == 0) return '0;
        u = (d << 12) / w;
        if (u >= 32768) return '0;
        p   = u * EXP_TABLE_DEPTH;
        idx = p >> 15;
        fr  = p & 32767;
        t0  = exp_tab[idx];
        t1  = exp_tab[idx + 1];
        if (t1 > t0) t1 = t0;
        return MU_W'(t0 - (((t0 - t1) * fr) >> 15));
    endfunction

    // queue the sixteen rule strengths of one state item
    task automatic predict_rules(input logic signed [VALUE_WIDTH-1:0] val [4]);
        logic [MU_W-1:0] mu [4][2];
        logic [MU_W-1:0] m;
        longint          lim;
        logic            fl;
        t_rule_res       r;
        for (int v = 0; v < 4; v++)
            for (int s = 0; s < 2; s++)
                mu[v][s] = set_membership(longint'(val[v]), longint'(sh_centre[v]), s[0]);
        lim = longint'(sh_limit);
        fl = (longint'(val[0]) < -lim) || (longint'(val[0]) > lim) ||
             (val[2] < sh_alo) || (val[2] > sh_ahi);
        for (int k = 0; k < 16; k++) begin
            m = mu[0][(k >> 3) & 1];
            if (mu[1][(k >> 2) & 1] < m) m = mu[1][(k >> 2) & 1];
            if (mu[2][(k >> 1) & 1] < m) m = mu[2][(k >> 1) & 1];
            if (mu[3][k & 1] < m) m = mu[3][k & 1];
            if (m == 0) m = 1;
            r.rule = RULE_W'(k);
            r.strength = m;
            r.last = (k == 15);
            r.failed = fl;
            rule_q.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // config write, only issued while the block is idle
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            REG_ANGLE_LOW:  sh_alo = val;
            REG_ANGLE_HIGH: sh_ahi = val;
            REG_WIDTH_FAC:  sh_factor = val[MAG_W-1:0];
            REG_POS_LIMIT:  sh_limit = val[MAG_W-1:0];
            default:        sh_centre[idx] = val[MAG_W-1:0];
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // write to an index past the register file: must change nothing
    task automatic write_bad_index(input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CIDX_W'(NUM_REGS + $urandom_range(0, 7));
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // push one state item; push drops after each accept and stays low through any random idle gap
    task automatic send_state(input logic signed [VALUE_WIDTH-1:0] val [4]);
        while ($urandom_range(0, 99) < push_idle_pct) begin
            @(posedge i_clk);
            push <= 1'b0;
        end
        @(posedge i_clk);
        push           <= 1'b1;
        i_position     <= val[0];
        i_velocity     <= val[1];
        i_angle        <= val[2];
        i_angular_rate <= val[3];
        predict_rules(val);
        do @(posedge i_clk); while (full);
        push <= 1'b0;
    endtask

    task automatic send_fields(input int a, input int b, input int c, input int d);
        logic signed [VALUE_WIDTH-1:0] val [4];
        val[0] = a; val[1] = b; val[2] = c; val[3] = d;
        send_state(val);
    endtask

    // random value, often near a set centre so the Gaussian slope is exercised
    function automatic int rand_field(input int mag);
        case ($urandom_range(0, 3))
            0:       return $signed(16'($urandom));
            1:       return mag + $urandom_range(0, 2 * mag + 1) - 2 * mag;
            2:       return -mag + $urandom_range(0, 2 * mag + 1) - mag / 2;
            default: return $urandom_range(0, 1) ? 32767 : -32768;
        endcase
    endfunction

    // wait until every queued result has come out, then a short drain gap
    task automatic drain_results();
        while (rule_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // receiver: random pop, compare each accepted result with the oldest expected
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (rule_q.size() == 0) begin
                report_mismatch("unexpected result", o_rule_index, 0);
            end else begin
                t_rule_res e;
                e = rule_q.pop_front();
                if (o_rule_index !== e.rule)
                    report_mismatch("rule_index", o_rule_index, e.rule);
                if (o_strength !== e.strength)
                    report_mismatch("strength", o_strength, e.strength);
                if (o_last_rule !== e.last)
                    report_mismatch("last_rule", o_last_rule, e.last);
                if (o_failed !== e.failed)
                    report_mismatch("failed", o_failed, e.failed);
            end
        end
        pop <= ($urandom_range(0, 99) >= pop_idle_pct);
    end

    // watchdog: cycles with no accept on either side
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt > 20000) begin
            $display("watchdog timeout");
            $display("== FAIL ==");
            $finish;
        end
    end

    // directed: field extremes, both set sides, fail window edges
    task automatic test_directed();
        send_fields(0, 0, 0, 0);
        send_fields(32767, 32767, 32767, 32767);
        send_fields(-32768, -32768, -32768, -32768);
        send_fields(6144, -2048, 7373, -205);
        send_fields(-6144, 2048, -7373, 205);
        send_fields(9830, 0, 858, 0);
        send_fields(9831, 0, 859, 0);
        send_fields(-9831, 100, -859, -100);
        send_fields(3000, -1000, 4000, 50);
        send_fields(-1, 1, -1, 1);
        send_fields(21845, -21846, 10922, -10923);
        drain_results();
    endtask

    // zero centre, zero width and an empty angle window
    task automatic test_corner_config();
        write_reg(REG_POS_CENTRE, 0);
        write_reg(REG_WIDTH_FAC, 0);
        write_reg(REG_ANGLE_LOW, 16'sd500);
        write_reg(REG_ANGLE_HIGH, -16'sd500);
        write_bad_index(16'hFFFF);
        send_fields(0, 100, 0, -100);
        send_fields(1, 2048, -3000, 205);
        send_fields(-1, -2048, 3000, -205);
        drain_results();
        // extremes of every register, upper data bit set for the narrow ones but the angle centre
        write_reg(REG_POS_CENTRE, 16'hFFFF);
        write_reg(REG_VEL_CENTRE, 16'hFFFF);
        write_reg(REG_ANG_CENTRE, 16'h7FFF);
        write_reg(REG_RATE_CENTRE, 16'h8000);
        write_reg(REG_WIDTH_FAC, 16'hFFFF);
        write_reg(REG_POS_LIMIT, 16'hFFFF);
        write_reg(REG_ANGLE_LOW, 16'h8000);
        write_reg(REG_ANGLE_HIGH, 16'h7FFF);
        send_fields(32767, -32768, 0, 12345);
        send_fields(-32768, 32767, -20000, 0);
        drain_results();
    endtask

    // random settings, random items with the given idle mix
    task automatic test_random(input int n_items, input int sp, input int rp);
        push_idle_pct = sp;
        pop_idle_pct  = rp;
        for (int r = 0; r < 8; r++)
            write_reg(t_reg_idx'(r), ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                     : 16'($urandom_range(0, 12000)));
        for (int n = 0; n < n_items; n++)
            send_fields(rand_field(sh_centre[0]), rand_field(sh_centre[1]),
                        rand_field(sh_centre[2]), rand_field(sh_centre[3]));
        drain_results();
    endtask

    initial begin
        for (int i = 0; i <= EXP_TABLE_DEPTH; i++)
            exp_tab[i] = gauss_sample(((64'd32 * i * i) << 16) / (EXP_TABLE_DEPTH ** 2));
        sh_centre[0] = 6144; sh_centre[1] = 2048; sh_centre[2] = 7373; sh_centre[3] = 205;
        sh_factor = 4096; sh_limit = 9830; sh_alo = -858; sh_ahi = 858;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        push_idle_pct = 32;
        pop_idle_pct  = 53;
        test_directed();
        test_corner_config();
        test_random(22, 32, 53);
        test_random(22, 32, 53);
        test_random(22, 53, 32);
        test_random(22, 53, 32);
        test_random(22, 0, 0);
        test_random(22, 0, 0);
        if (err_cnt == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
